[rtl/srsw_pkg.sv]
package srsw_pkg;

    localparam int SEQ_COUNT_DEF    = 8;
    localparam int PAYLOAD_BITS_DEF = 32;
    localparam int CHECKSUM_W       = 16;
    localparam int WIN_W            = 3;
    localparam logic [WIN_W-1:0] WIN_RESET = 3'd4;

    // Item codes carried on the mode field; the fourth code means nothing.
    typedef enum logic [1:0] {
        MODE_SEND    = 2'd0,
        MODE_ACK     = 2'd1,
        MODE_TIMEOUT = 2'd2
    } t_mode;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_SLIDE = 4'b0010,
        S_READ  = 4'b0100,
        S_DONE  = 4'b1000
    } t_state;

    // Single-bit flags of one result transaction.
    typedef struct packed {
        logic accepted;
        logic tx_valid;
        logic timer_start;
        logic timer_stop;
    } t_ctl;

endpackage

[rtl/selective_repeat_sender_window_top.sv]
// Selective-repeat ARQ sender window.
// Input channel (i_in_valid / o_in_ready) carries one event per transaction:
// a new packet to send, an acknowledgement, or a timer expiry, chosen by
// i_mode. Every input transaction yields exactly one result transaction on
// the output channel (o_out_valid / i_out_ready), which reports whether a
// send was taken, any packet to put on the network, any timer request and
// the window edges after the event.
// The configuration channel (i_cfg_valid / o_cfg_ready) writes the window
// size; it is always ready and is meant to be used only while the block is
// idle. A size of zero acts as one and sizes above half the sequence space
// act as half of it.
// A send, a corrupt ack or an ack outside the window goes straight from the
// idle state to the done state; a timeout first passes the read state (one
// read on the packet RAM) and an ack inside the window passes the slide
// state, which advances the base over each acked entry. Only one event is
// in the control unit at a time; the next is taken once its result leaves.
// The output register holds a finished result while the receiver stalls;
// the next event is accepted meanwhile and waits in the control unit. After
// reset the window is empty, base and next number are zero, the window size
// is four and the packet RAM holds no valid data until written by sends.
module selective_repeat_sender_window_top
    import srsw_pkg::*;
#(
    parameter int SEQ_COUNT    = SEQ_COUNT_DEF,
    parameter int PAYLOAD_BITS = PAYLOAD_BITS_DEF,
    parameter int SEQ_W        = $clog2(SEQ_COUNT)
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [WIN_W-1:0]        i_window_size,
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  logic [1:0]              i_mode,
    input  logic [PAYLOAD_BITS-1:0] i_payload,
    input  logic [CHECKSUM_W-1:0]   i_packet_checksum,
    input  logic [SEQ_W-1:0]        i_ack_seq,
    input  logic                    i_ack_good,
    input  logic [SEQ_W-1:0]        i_expired_seq,
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output logic                    o_accepted,
    output logic                    o_tx_valid,
    output logic [SEQ_W-1:0]        o_tx_seq,
    output logic [PAYLOAD_BITS-1:0] o_tx_payload,
    output logic [CHECKSUM_W-1:0]   o_tx_checksum,
    output logic                    o_timer_start,
    output logic                    o_timer_stop,
    output logic [SEQ_W-1:0]        o_timer_seq,
    output logic [SEQ_W-1:0]        o_window_base,
    output logic [SEQ_W-1:0]        o_next_send_seq
);

    localparam int RAM_W = PAYLOAD_BITS + CHECKSUM_W;

    logic                    w_ram_we;
    logic [SEQ_W-1:0]        w_ram_waddr;
    logic [RAM_W-1:0]        w_ram_wdata;
    logic                    w_ram_re;
    logic [SEQ_W-1:0]        w_ram_raddr;
    logic [RAM_W-1:0]        w_ram_rdata;

    logic                    w_res_valid;
    logic                    w_res_ready;
    t_ctl                    w_res_ctl;
    logic [SEQ_W-1:0]        w_res_tx_seq;
    logic [PAYLOAD_BITS-1:0] w_res_payload;
    logic [CHECKSUM_W-1:0]   w_res_checksum;
    logic [SEQ_W-1:0]        w_res_timer_seq;
    logic [SEQ_W-1:0]        w_res_base;
    logic [SEQ_W-1:0]        w_res_next;

    logic                    r_out_valid;
    t_ctl                    r_out_ctl;
    logic [SEQ_W-1:0]        r_out_tx_seq;
    logic [PAYLOAD_BITS-1:0] r_out_payload;
    logic [CHECKSUM_W-1:0]   r_out_checksum;
    logic [SEQ_W-1:0]        r_out_timer_seq;
    logic [SEQ_W-1:0]        r_out_base;
    logic [SEQ_W-1:0]        r_out_next;
    logic                    w_load;

    // Payload and checksum of each outstanding packet, indexed by sequence number.
    srsw_ram #(
        .WIDTH (RAM_W),
        .DEPTH (SEQ_COUNT)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_re    (w_ram_re),
        .i_raddr (w_ram_raddr),
        .o_rdata (w_ram_rdata)
    );

    srsw_ctrl #(
        .SEQ_COUNT    (SEQ_COUNT),
        .PAYLOAD_BITS (PAYLOAD_BITS),
        .SEQ_W        (SEQ_W),
        .RAM_W        (RAM_W)
    ) u_ctrl (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_valid       (i_cfg_valid),
        .i_window_size     (i_window_size),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_mode            (i_mode),
        .i_payload         (i_payload),
        .i_packet_checksum (i_packet_checksum),
        .i_ack_seq         (i_ack_seq),
        .i_ack_good        (i_ack_good),
        .i_expired_seq     (i_expired_seq),
        .o_ram_we          (w_ram_we),
        .o_ram_waddr       (w_ram_waddr),
        .o_ram_wdata       (w_ram_wdata),
        .o_ram_re          (w_ram_re),
        .o_ram_raddr       (w_ram_raddr),
        .i_ram_rdata       (w_ram_rdata),
        .o_res_valid       (w_res_valid),
        .i_res_ready       (w_res_ready),
        .o_res_ctl         (w_res_ctl),
        .o_res_tx_seq      (w_res_tx_seq),
        .o_res_payload     (w_res_payload),
        .o_res_checksum    (w_res_checksum),
        .o_res_timer_seq   (w_res_timer_seq),
        .o_res_base        (w_res_base),
        .o_res_next        (w_res_next)
    );

    // The output register takes a new result whenever it is empty or is
    // being drained in the same cycle.
    assign w_res_ready = !r_out_valid || i_out_ready;
    assign w_load      = w_res_valid && w_res_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res_ready) begin
            r_out_valid <= w_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_ctl       <= w_res_ctl;
            r_out_tx_seq    <= w_res_tx_seq;
            r_out_payload   <= w_res_payload;
            r_out_checksum  <= w_res_checksum;
            r_out_timer_seq <= w_res_timer_seq;
            r_out_base      <= w_res_base;
            r_out_next      <= w_res_next;
        end
    end

    assign o_cfg_ready     = 1'b1;
    assign o_out_valid     = r_out_valid;
    assign o_accepted      = r_out_ctl.accepted;
    assign o_tx_valid      = r_out_ctl.tx_valid;
    assign o_timer_start   = r_out_ctl.timer_start;
    assign o_timer_stop    = r_out_ctl.timer_stop;
    assign o_tx_seq        = r_out_tx_seq;
    assign o_tx_payload    = r_out_payload;
    assign o_tx_checksum   = r_out_checksum;
    assign o_timer_seq     = r_out_timer_seq;
    assign o_window_base   = r_out_base;
    assign o_next_send_seq = r_out_next;

endmodule

[rtl/srsw_ram.sv]
module srsw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/srsw_ctrl.sv]
module srsw_ctrl
    import srsw_pkg::*;
#(
    parameter int SEQ_COUNT    = SEQ_COUNT_DEF,
    parameter int PAYLOAD_BITS = PAYLOAD_BITS_DEF,
    parameter int SEQ_W        = $clog2(SEQ_COUNT),
    parameter int RAM_W        = PAYLOAD_BITS + CHECKSUM_W
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_valid,
    input  logic [WIN_W-1:0]        i_window_size,
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  logic [1:0]              i_mode,
    input  logic [PAYLOAD_BITS-1:0] i_payload,
    input  logic [CHECKSUM_W-1:0]   i_packet_checksum,
    input  logic [SEQ_W-1:0]        i_ack_seq,
    input  logic                    i_ack_good,
    input  logic [SEQ_W-1:0]        i_expired_seq,
    output logic                    o_ram_we,
    output logic [SEQ_W-1:0]        o_ram_waddr,
    output logic [RAM_W-1:0]        o_ram_wdata,
    output logic                    o_ram_re,
    output logic [SEQ_W-1:0]        o_ram_raddr,
    input  logic [RAM_W-1:0]        i_ram_rdata,
    output logic                    o_res_valid,
    input  logic                    i_res_ready,
    output t_ctl                    o_res_ctl,
    output logic [SEQ_W-1:0]        o_res_tx_seq,
    output logic [PAYLOAD_BITS-1:0] o_res_payload,
    output logic [CHECKSUM_W-1:0]   o_res_checksum,
    output logic [SEQ_W-1:0]        o_res_timer_seq,
    output logic [SEQ_W-1:0]        o_res_base,
    output logic [SEQ_W-1:0]        o_res_next
);

    localparam logic [SEQ_W:0]   SEQ_CNT_V = (SEQ_W+1)'(SEQ_COUNT);
    localparam logic [SEQ_W:0]   HALF_V    = (SEQ_W+1)'(SEQ_COUNT / 2);
    localparam logic [SEQ_W-1:0] SEQ_LAST  = SEQ_W'(SEQ_COUNT - 1);

    function automatic logic [SEQ_W-1:0] f_inc(input logic [SEQ_W-1:0] s);
        f_inc = (s == SEQ_LAST) ? '0 : s + 1'b1;
    endfunction

    // Distance from b forward to a, modulo the sequence space.
    function automatic logic [SEQ_W-1:0] f_dist(input logic [SEQ_W-1:0] a,
                                                input logic [SEQ_W-1:0] b);
        logic [SEQ_W:0] d;
        d = {1'b0, a} - {1'b0, b};
        if (a < b) begin
            d = d + SEQ_CNT_V;
        end
        f_dist = d[SEQ_W-1:0];
    endfunction

    t_state                  r_state, n_state;
    logic [SEQ_W-1:0]        r_base, n_base;
    logic [SEQ_W-1:0]        r_next, n_next;
    logic [SEQ_COUNT-1:0]    r_acked, n_acked;
    logic [WIN_W-1:0]        r_win;
    t_ctl                    r_ctl, n_ctl;
    logic [SEQ_W-1:0]        r_tx_seq, n_tx_seq;
    logic [PAYLOAD_BITS-1:0] r_payload, n_payload;
    logic [CHECKSUM_W-1:0]   r_checksum, n_checksum;
    logic [SEQ_W-1:0]        r_timer_seq, n_timer_seq;
    logic [SEQ_W-1:0]        r_out_base, n_out_base;
    logic [SEQ_W-1:0]        r_out_next, n_out_next;

    logic [SEQ_W:0]   w_win_ext;
    logic [SEQ_W:0]   w_eff;
    logic [SEQ_W:0]   w_sum;
    logic [SEQ_W:0]   w_limit;
    logic             w_full;
    logic             w_in_win;
    logic [SEQ_W:0]   w_exp_ext;
    logic [SEQ_W-1:0] w_exp;

    always_comb begin
        w_win_ext = (SEQ_W+1)'(r_win);
        if (w_win_ext == '0) begin
            w_eff = (SEQ_W+1)'(1);
        end else if (w_win_ext > HALF_V) begin
            w_eff = HALF_V;
        end else begin
            w_eff = w_win_ext;
        end
        w_sum   = {1'b0, r_base} + w_eff;
        w_limit = (w_sum >= SEQ_CNT_V) ? w_sum - SEQ_CNT_V : w_sum;
        w_full  = (w_limit[SEQ_W-1:0] == r_next);

        w_in_win = ({1'b0, i_ack_seq} < SEQ_CNT_V)
                && (f_dist(i_ack_seq, r_base) < f_dist(r_next, r_base));

        w_exp_ext = {1'b0, i_expired_seq};
        if (w_exp_ext >= SEQ_CNT_V) begin
            w_exp_ext = w_exp_ext - SEQ_CNT_V;
        end
        w_exp = w_exp_ext[SEQ_W-1:0];
    end

    always_comb begin
        n_state     = r_state;
        n_base      = r_base;
        n_next      = r_next;
        n_acked     = r_acked;
        n_ctl       = r_ctl;
        n_tx_seq    = r_tx_seq;
        n_payload   = r_payload;
        n_checksum  = r_checksum;
        n_timer_seq = r_timer_seq;
        n_out_base  = r_out_base;
        n_out_next  = r_out_next;
        o_ram_we    = 1'b0;
        o_ram_waddr = r_next;
        o_ram_wdata = {i_packet_checksum, i_payload};
        o_ram_re    = 1'b0;
        o_ram_raddr = w_exp;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_ctl       = '0;
                    n_tx_seq    = '0;
                    n_payload   = '0;
                    n_checksum  = '0;
                    n_timer_seq = '0;
                    n_out_base  = r_base;
                    n_out_next  = r_next;
                    n_state     = S_DONE;
                    case (t_mode'(i_mode))
                        MODE_SEND: begin
                            if (!w_full) begin
                                o_ram_we          = 1'b1;
                                n_ctl.accepted    = 1'b1;
                                n_ctl.tx_valid    = 1'b1;
                                n_ctl.timer_start = 1'b1;
                                n_tx_seq          = r_next;
                                n_timer_seq       = r_next;
                                n_payload         = i_payload;
                                n_checksum        = i_packet_checksum;
                                n_next            = f_inc(r_next);
                                n_out_next        = f_inc(r_next);
                            end
                        end
                        MODE_ACK: begin
                            if (i_ack_good) begin
                                n_ctl.timer_stop = 1'b1;
                                n_timer_seq      = i_ack_seq;
                                if (w_in_win) begin
                                    n_acked[i_ack_seq] = 1'b1;
                                    n_state            = S_SLIDE;
                                end
                            end
                        end
                        MODE_TIMEOUT: begin
                            o_ram_re          = 1'b1;
                            n_ctl.tx_valid    = 1'b1;
                            n_ctl.timer_start = 1'b1;
                            n_tx_seq          = w_exp;
                            n_timer_seq       = w_exp;
                            n_state           = S_READ;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_SLIDE: begin
                if (r_acked[r_base]) begin
                    n_acked[r_base] = 1'b0;
                    n_base          = f_inc(r_base);
                end else begin
                    n_out_base = r_base;
                    n_state    = S_DONE;
                end
            end
            S_READ: begin
                n_payload  = i_ram_rdata[PAYLOAD_BITS-1:0];
                n_checksum = i_ram_rdata[RAM_W-1:PAYLOAD_BITS];
                n_state    = S_DONE;
            end
            S_DONE: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_base  <= '0;
            r_next  <= '0;
            r_acked <= '0;
            r_win   <= WIN_RESET;
        end else begin
            r_state <= n_state;
            r_base  <= n_base;
            r_next  <= n_next;
            r_acked <= n_acked;
            if (i_cfg_valid) begin
                r_win <= i_window_size;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_ctl       <= n_ctl;
        r_tx_seq    <= n_tx_seq;
        r_payload   <= n_payload;
        r_checksum  <= n_checksum;
        r_timer_seq <= n_timer_seq;
        r_out_base  <= n_out_base;
        r_out_next  <= n_out_next;
    end

    assign o_in_ready      = (r_state == S_IDLE);
    assign o_res_valid     = (r_state == S_DONE);
    assign o_res_ctl       = r_ctl;
    assign o_res_tx_seq    = r_tx_seq;
    assign o_res_payload   = r_payload;
    assign o_res_checksum  = r_checksum;
    assign o_res_timer_seq = r_timer_seq;
    assign o_res_base      = r_out_base;
    assign o_res_next      = r_out_next;

endmodule

[rtl/srsw_checker.sv]
module srsw_checker
    import srsw_pkg::*;
#(
    parameter int SEQ_W        = 3,
    parameter int PAYLOAD_BITS = PAYLOAD_BITS_DEF
) (
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    o_out_valid,
    input logic                    i_out_ready,
    input logic                    o_accepted,
    input logic                    o_tx_valid,
    input logic [SEQ_W-1:0]        o_tx_seq,
    input logic [PAYLOAD_BITS-1:0] o_tx_payload,
    input logic                    o_timer_start,
    input logic                    o_timer_stop,
    input logic [SEQ_W-1:0]        o_timer_seq
);

    // A stalled result holds its packet.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_tx_payload)
                                        && $stable(o_tx_seq))
        else $error("stalled result changed");

    // Every emitted packet arms its own timer.
    a_tx_timer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_tx_valid |-> o_timer_start && (o_timer_seq == o_tx_seq))
        else $error("emitted packet without matching timer start");

    // A taken send always emits a packet.
    a_accept_tx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_accepted |-> o_tx_valid)
        else $error("accepted send without packet");

    // An acknowledgement never starts a timer or emits a packet.
    a_stop_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_timer_stop |-> !o_timer_start && !o_tx_valid && !o_accepted)
        else $error("timer stop mixed with other requests");

endmodule

bind selective_repeat_sender_window_top srsw_checker #(
    .SEQ_W        (SEQ_W),
    .PAYLOAD_BITS (PAYLOAD_BITS)
) u_srsw_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .o_accepted    (o_accepted),
    .o_tx_valid    (o_tx_valid),
    .o_tx_seq      (o_tx_seq),
    .o_tx_payload  (o_tx_payload),
    .o_timer_start (o_timer_start),
    .o_timer_stop  (o_timer_stop),
    .o_timer_seq   (o_timer_seq)
);
